[rtl/core/bhbd_pkg.sv]
// ----------------------------------------------------------------------------
// bhbd_pkg
// Shared types and constants of the border histogram background detector.
// ----------------------------------------------------------------------------
package bhbd_pkg;

  localparam int GRAY_W      = 8;
  localparam int GRAY_BINS   = 256;
  localparam int BIN_W       = 17;
  localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};
  localparam int STRIPS      = 4;
  localparam int SCAN_W      = $clog2(GRAY_BINS) + 1;

  // strip order: top, bottom, left, right
  localparam int STRIP_TOP    = 0;
  localparam int STRIP_BOTTOM = 1;
  localparam int STRIP_LEFT   = 2;
  localparam int STRIP_RIGHT  = 3;

  localparam int DIM_CFG_W   = 13;
  localparam int THICK_CFG_W = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;

  localparam int MAX_DIM_DEF       = 4096;
  localparam int MAX_THICKNESS_DEF = 16;

  localparam logic [DIM_CFG_W-1:0]   WIDTH_RST  = 13'd640;
  localparam logic [DIM_CFG_W-1:0]   HEIGHT_RST = 13'd480;
  localparam logic [THICK_CFG_W-1:0] THICK_RST  = 5'd5;
  localparam logic [GRAY_W-1:0]      GLOW_RST   = 8'd110;
  localparam logic [GRAY_W-1:0]      GHIGH_RST  = 8'd160;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_THICKNESS    = 3'd2,
    CFG_GRAY_LOW     = 3'd3,
    CFG_GRAY_HIGH    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic accept;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_pixel;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

[rtl/core/border_histogram_background_detect_top.sv]
// ----------------------------------------------------------------------------
// border_histogram_background_detect_top
// Four border-strip gray histograms per frame, peak search, background flag.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle within a frame.
// After the last pixel of a frame the input stalls for the final bin write,
// the shared 256-bin peak scan and the hand-over of the result, which waits
// until the result register is free and then makes the result valid.
// Reset: all histograms read as empty and the raster position returns to the
// first pixel; configuration returns to 640 x 480, thickness 5, window 110..160.
module border_histogram_background_detect_top #(
  parameter int MAX_DIM       = bhbd_pkg::MAX_DIM_DEF,
  parameter int MAX_THICKNESS = bhbd_pkg::MAX_THICKNESS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [bhbd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bhbd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // pixel stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bhbd_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] pixel
  // result stream, one item per frame
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] has_background, [3:1] peaks_in_window, [11:4] peak_top,
  // [19:12] peak_bottom, [27:20] peak_left, [35:28] peak_right, [39:36] zero
  output logic [bhbd_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  bhbd_pkg::cmd_t    cmd;
  bhbd_pkg::status_t sts;

  // sequencer: hold the input during the final write, the peak scan and the hand-over
  bhbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: position, strip sort, histograms, scan and result register;
  // the next frame may start while the result still waits to be taken
  bhbd_datapath #(
    .MAX_DIM       (MAX_DIM),
    .MAX_THICKNESS (MAX_THICKNESS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (s_axis_tdata[bhbd_pkg::GRAY_W-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

[rtl/core/bhbd_hist_ram.sv]
// ----------------------------------------------------------------------------
// bhbd_hist_ram
// One strip histogram: 256 bins with per-bin valid flags, registered read.
// ----------------------------------------------------------------------------
module bhbd_hist_ram (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bhbd_pkg::GRAY_W-1:0]    rd_addr_i,
  input  logic                           wr_en_i,
  input  logic [bhbd_pkg::GRAY_W-1:0]    wr_addr_i,
  input  logic [bhbd_pkg::BIN_W-1:0]     wr_data_i,
  input  logic                           clr_i,
  output logic [bhbd_pkg::BIN_W-1:0]     rd_data_o
);

  logic [bhbd_pkg::BIN_W-1:0]     mem [bhbd_pkg::GRAY_BINS];
  logic [bhbd_pkg::GRAY_BINS-1:0] vld_q;
  logic [bhbd_pkg::BIN_W-1:0]     rd_q;
  logic                           rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  // a bin never written since the last clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr_i];
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

[rtl/core/bhbd_ctrl.sv]
// ----------------------------------------------------------------------------
// bhbd_ctrl
// Frame sequencer: pixel intake, last write, peak scan, result hand-over.
// ----------------------------------------------------------------------------
module bhbd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bhbd_pkg::status_t sts_i,
  output bhbd_pkg::cmd_t    cmd_o
);

  bhbd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bhbd_pkg::ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bhbd_pkg::ST_RUN: begin
        if (in_valid_i && sts_i.last_pixel) begin
          state_d = bhbd_pkg::ST_FLUSH;
        end
      end
      bhbd_pkg::ST_FLUSH: state_d = bhbd_pkg::ST_SCAN;
      bhbd_pkg::ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = bhbd_pkg::ST_FIN;
        end
      end
      bhbd_pkg::ST_FIN: begin
        if (sts_i.out_free) begin
          state_d = bhbd_pkg::ST_RUN;
        end
      end
      default: state_d = bhbd_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      bhbd_pkg::ST_RUN: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      bhbd_pkg::ST_SCAN: cmd_o.scan = 1'b1;
      bhbd_pkg::ST_FIN:  cmd_o.finish = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/core/bhbd_datapath.sv]
// ----------------------------------------------------------------------------
// bhbd_datapath
// Configuration, raster position, strip sorting, histogram update with
// forwarding, peak scan and the result register.
// ----------------------------------------------------------------------------
module bhbd_datapath #(
  parameter int MAX_DIM       = bhbd_pkg::MAX_DIM_DEF,
  parameter int MAX_THICKNESS = bhbd_pkg::MAX_THICKNESS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bhbd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bhbd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [bhbd_pkg::GRAY_W-1:0]       pixel_i,
  input  bhbd_pkg::cmd_t                    cmd_i,
  output bhbd_pkg::status_t                 sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bhbd_pkg::OUT_DATA_W-1:0]   out_data_o
);

  localparam int POS_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int EW    = ((DIM_W > bhbd_pkg::DIM_CFG_W) ? DIM_W : bhbd_pkg::DIM_CFG_W) + 1;
  localparam int G_W   = bhbd_pkg::GRAY_W;
  localparam int B_W   = bhbd_pkg::BIN_W;
  localparam int NS    = bhbd_pkg::STRIPS;

  // configuration registers
  logic [bhbd_pkg::DIM_CFG_W-1:0]   width_q, height_q;
  logic [bhbd_pkg::THICK_CFG_W-1:0] thick_q;
  logic [G_W-1:0]                   glow_q, ghigh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bhbd_pkg::WIDTH_RST;
      height_q <= bhbd_pkg::HEIGHT_RST;
      thick_q  <= bhbd_pkg::THICK_RST;
      glow_q   <= bhbd_pkg::GLOW_RST;
      ghigh_q  <= bhbd_pkg::GHIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bhbd_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data_i[bhbd_pkg::DIM_CFG_W-1:0];
        bhbd_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data_i[bhbd_pkg::DIM_CFG_W-1:0];
        bhbd_pkg::CFG_THICKNESS:    thick_q  <= cfg_data_i[bhbd_pkg::THICK_CFG_W-1:0];
        bhbd_pkg::CFG_GRAY_LOW:     glow_q   <= cfg_data_i[G_W-1:0];
        bhbd_pkg::CFG_GRAY_HIGH:    ghigh_q  <= cfg_data_i[G_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated frame geometry, all widened to EW bits
  logic [EW-1:0] w_e, h_e, t_e, fw_e, fh_e, ft_e, c_e, r_e;

  always_comb begin
    fw_e = EW'(width_q);
    fh_e = EW'(height_q);
    ft_e = EW'(thick_q);
    if (fw_e == '0)               w_e = EW'(1);
    else if (fw_e > EW'(MAX_DIM)) w_e = EW'(MAX_DIM);
    else                          w_e = fw_e;
    if (fh_e == '0)               h_e = EW'(1);
    else if (fh_e > EW'(MAX_DIM)) h_e = EW'(MAX_DIM);
    else                          h_e = fh_e;
    if (ft_e == '0)                     t_e = EW'(1);
    else if (ft_e > EW'(MAX_THICKNESS)) t_e = EW'(MAX_THICKNESS);
    else                                t_e = ft_e;
  end

  // raster position
  logic [POS_W-1:0] col_q, row_q;
  logic             col_wrap, row_wrap;

  assign c_e      = EW'(col_q);
  assign r_e      = EW'(row_q);
  assign col_wrap = (c_e + EW'(1)) >= w_e;
  assign row_wrap = (r_e + EW'(1)) >= h_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      if (!col_wrap) begin
        col_q <= col_q + POS_W'(1);
      end else begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_q + POS_W'(1);
      end
    end
  end

  // strip membership of the pixel now on the input
  logic [NS-1:0] mask;
  logic          middle;

  always_comb begin
    middle = (r_e >= t_e) && ((r_e + t_e) < h_e);
    mask[bhbd_pkg::STRIP_TOP]    = r_e < t_e;
    mask[bhbd_pkg::STRIP_BOTTOM] = (r_e + t_e) >= h_e;
    mask[bhbd_pkg::STRIP_LEFT]   = middle && (c_e < t_e);
    mask[bhbd_pkg::STRIP_RIGHT]  = middle && ((c_e + t_e) >= w_e);
  end

  // update stage: read issued at accept, written back in the next cycle
  logic          s1_vld_q;
  logic [G_W-1:0] s1_gray_q;
  logic [NS-1:0] s1_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s1_gray_q <= pixel_i;
      s1_mask_q <= mask;
    end
  end

  // scan address and compare stage
  logic [bhbd_pkg::SCAN_W-1:0] scan_cnt_q;
  logic                        cmp_vld_q;
  logic [G_W-1:0]              cmp_idx_q;
  logic [G_W-1:0]              rd_addr;

  assign rd_addr = cmd_i.scan ? scan_cnt_q[G_W-1:0] : pixel_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      cmp_vld_q  <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan && !scan_cnt_q[bhbd_pkg::SCAN_W-1];
      if (cmd_i.finish) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan && !scan_cnt_q[bhbd_pkg::SCAN_W-1]) begin
        scan_cnt_q <= scan_cnt_q + bhbd_pkg::SCAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= scan_cnt_q[G_W-1:0];
  end

  // the last write address is shared by all strips
  logic [G_W-1:0] wr_addr_q;

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      wr_addr_q <= s1_gray_q;
    end
  end

  logic [G_W-1:0] peak [NS];
  logic [NS-1:0]  in_win;

  for (genvar s = 0; s < NS; s++) begin : g_strip
    logic [B_W-1:0] rd_data, cur, nxt, best_q;
    logic [B_W-1:0] wr_data_q;
    logic           wr_vld_q, wr_en;
    logic [G_W-1:0] best_idx_q;

    assign wr_en = s1_vld_q && s1_mask_q[s];

    // forward the bin written at the same edge as this read
    always_comb begin
      cur = (wr_vld_q && (wr_addr_q == s1_gray_q)) ? wr_data_q : rd_data;
      nxt = (cur == bhbd_pkg::BIN_MAX) ? cur : cur + B_W'(1);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        wr_vld_q <= 1'b0;
      end else begin
        wr_vld_q <= wr_en;
      end
    end

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        wr_data_q <= nxt;
      end
      // tie keeps the lower bin
      if (cmp_vld_q && ((cmp_idx_q == '0) || (rd_data > best_q))) begin
        best_q     <= rd_data;
        best_idx_q <= cmp_idx_q;
      end
    end

    bhbd_hist_ram u_ram (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .rd_addr_i (rd_addr),
      .wr_en_i   (wr_en),
      .wr_addr_i (s1_gray_q),
      .wr_data_i (nxt),
      .clr_i     (cmd_i.finish),
      .rd_data_o (rd_data)
    );

    assign peak[s]   = best_idx_q;
    assign in_win[s] = (best_idx_q >= glow_q) && (best_idx_q <= ghigh_q);
  end

  logic [2:0] n_win;

  assign n_win = 3'(in_win[0]) + 3'(in_win[1]) + 3'(in_win[2]) + 3'(in_win[3]);

  // result register
  logic                              out_vld_q;
  logic [bhbd_pkg::OUT_DATA_W-1:0]   out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= {4'd0,
                peak[bhbd_pkg::STRIP_RIGHT], peak[bhbd_pkg::STRIP_LEFT],
                peak[bhbd_pkg::STRIP_BOTTOM], peak[bhbd_pkg::STRIP_TOP],
                n_win, (n_win > 3'd1)};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign sts_o.last_pixel = col_wrap && row_wrap;
  assign sts_o.scan_done  = scan_cnt_q[bhbd_pkg::SCAN_W-1];
  assign sts_o.out_free   = !out_vld_q || out_ready_i;

endmodule
